### hdl/ictl_pkg.sv
package ictl_pkg;

	localparam int unsigned NODE_COUNT    = 262144;
	localparam int unsigned NODE_AW       = $clog2(NODE_COUNT);
	localparam int unsigned COUNTRY_COUNT = 255;

	localparam int unsigned NODE_IDX_W = 18;
	localparam int unsigned PTR_W      = 24;
	localparam int unsigned IP_W       = 32;
	localparam int unsigned LEVEL_W    = $clog2(IP_W);
	localparam int unsigned NODE_W     = 2 * PTR_W;
	localparam int unsigned IDX_W      = 8;
	localparam int unsigned ST_W       = 3;

	localparam logic [PTR_W-1:0]   TERMINAL_BASE = PTR_W'(16776960);
	localparam logic [LEVEL_W-1:0] TOP_BIT       = LEVEL_W'(31);

	localparam int unsigned S_TDATA_W = 104;
	localparam int unsigned M_TDATA_W = 16;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = 1;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	localparam logic [ST_W-1:0] ST_FOUND     = 3'd0;
	localparam logic [ST_W-1:0] ST_DISABLED  = 3'd1;
	localparam logic [ST_W-1:0] ST_RANGE     = 3'd2;
	localparam logic [ST_W-1:0] ST_EXHAUSTED = 3'd3;
	localparam logic [ST_W-1:0] ST_BEYOND    = 3'd4;

	typedef struct packed {
		logic                  op;
		logic [NODE_IDX_W-1:0] node_index;
		logic [PTR_W-1:0]      left_pointer;
		logic [PTR_W-1:0]      right_pointer;
		logic [IP_W-1:0]       ip_address;
	} item_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] country_index;
	} result_t;

endpackage

### hdl/ictl_ram.sv
module ictl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### hdl/ictl_front.sv
module ictl_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ictl_pkg::S_TDATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	output logic                           q_valid,
	output ictl_pkg::item_t                q_item,
	input  logic                           q_pop
);

	ictl_pkg::item_t                in_item;
	ictl_pkg::item_t                slot_q [ictl_pkg::QUEUE_DEPTH];
	logic [ictl_pkg::QUEUE_AW-1:0]  wr_ptr_q;
	logic [ictl_pkg::QUEUE_AW-1:0]  rd_ptr_q;
	logic [ictl_pkg::QUEUE_AW:0]    count_q;
	logic                           push;

	// tdata: node_index, left_pointer, right_pointer, ip_address; tuser: command
	always_comb begin
		in_item.op            = s_tuser ? ictl_pkg::OP_LOOKUP : ictl_pkg::OP_WRITE;
		in_item.node_index    = s_tdata[17:0];
		in_item.left_pointer  = s_tdata[41:18];
		in_item.right_pointer = s_tdata[65:42];
		in_item.ip_address    = s_tdata[97:66];
	end

	assign s_tready = (count_q != (ictl_pkg::QUEUE_AW+1)'(ictl_pkg::QUEUE_DEPTH));
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != '0);
	assign q_item   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && q_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/ictl_back.sv
module ictl_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           lookup_enable,
	input  logic                           q_valid,
	input  ictl_pkg::item_t                q_item,
	output logic                           q_pop,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ictl_pkg::M_TDATA_W-1:0] m_tdata
);

	localparam logic [0:0] BK_IDLE = 1'b0;
	localparam logic [0:0] BK_WALK = 1'b1;

	logic [0:0]                         state_q;
	logic [ictl_pkg::LEVEL_W-1:0]       level_q;
	logic [ictl_pkg::IP_W-1:0]          ip_q;
	logic                               pend_valid_q;
	ictl_pkg::result_t                  pend_q;
	logic                               out_valid_q;
	ictl_pkg::result_t                  out_q;

	logic                               ram_we;
	logic [ictl_pkg::NODE_AW-1:0]       ram_waddr;
	logic [ictl_pkg::NODE_W-1:0]        ram_wdata;
	logic                               ram_re;
	logic [ictl_pkg::NODE_AW-1:0]       ram_raddr;
	logic [ictl_pkg::NODE_W-1:0]        ram_rdata;

	logic [ictl_pkg::PTR_W-1:0]         sel_ptr;
	logic [ictl_pkg::PTR_W-1:0]         code;
	logic                               is_term;
	logic                               beyond;
	logic                               walk_done;
	ictl_pkg::result_t                  walk_res;
	logic                               out_free;

	ictl_ram #(
		.WIDTH(ictl_pkg::NODE_W),
		.DEPTH(ictl_pkg::NODE_COUNT)
	) u_node_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign q_pop    = q_valid && (state_q == BK_IDLE) && !pend_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		sel_ptr = ip_q[level_q] ? ram_rdata[ictl_pkg::NODE_W-1:ictl_pkg::PTR_W]
		                        : ram_rdata[ictl_pkg::PTR_W-1:0];
		is_term = (sel_ptr >= ictl_pkg::TERMINAL_BASE);
		code    = sel_ptr - ictl_pkg::TERMINAL_BASE;
		beyond  = (32'(sel_ptr) >= ictl_pkg::NODE_COUNT);

		walk_done               = 1'b1;
		walk_res.status         = ictl_pkg::ST_FOUND;
		walk_res.country_index  = '0;
		if (is_term) begin
			if (32'(code) >= ictl_pkg::COUNTRY_COUNT) begin
				walk_res.status = ictl_pkg::ST_RANGE;
			end else begin
				walk_res.country_index = code[ictl_pkg::IDX_W-1:0];
			end
		end else if (level_q == '0) begin
			walk_res.status = ictl_pkg::ST_EXHAUSTED;
		end else if (beyond) begin
			walk_res.status = ictl_pkg::ST_BEYOND;
		end else begin
			walk_done = 1'b0;
		end

		ram_waddr = q_item.node_index[ictl_pkg::NODE_AW-1:0];
		ram_wdata = {q_item.right_pointer, q_item.left_pointer};
		ram_we    = q_pop && (q_item.op == ictl_pkg::OP_WRITE)
		            && (32'(q_item.node_index) < ictl_pkg::NODE_COUNT);
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (q_pop && (q_item.op == ictl_pkg::OP_LOOKUP) && lookup_enable) begin
			ram_re = 1'b1;
		end else if ((state_q == BK_WALK) && !walk_done) begin
			ram_re    = 1'b1;
			ram_raddr = sel_ptr[ictl_pkg::NODE_AW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			case (state_q)
				BK_IDLE: begin
					if (q_pop && (q_item.op == ictl_pkg::OP_LOOKUP)) begin
						if (lookup_enable) begin
							state_q <= BK_WALK;
						end else begin
							pend_valid_q <= 1'b1;
						end
					end
				end
				BK_WALK: begin
					if (walk_done) begin
						state_q      <= BK_IDLE;
						pend_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
			if (pend_valid_q && out_free) begin
				pend_valid_q <= 1'b0;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			ip_q    <= q_item.ip_address;
			level_q <= ictl_pkg::TOP_BIT;
		end else if (state_q == BK_WALK) begin
			level_q <= level_q - 1'b1;
		end
		if (q_pop && (q_item.op == ictl_pkg::OP_LOOKUP) && !lookup_enable) begin
			pend_q.status        <= ictl_pkg::ST_DISABLED;
			pend_q.country_index <= '0;
		end else if ((state_q == BK_WALK) && walk_done) begin
			pend_q <= walk_res;
		end
		if (pend_valid_q && out_free) begin
			out_q <= pend_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = ictl_pkg::M_TDATA_W'(out_q);

endmodule

### hdl/ip_country_trie_lookup.sv
// a write reaches the node store when the back end pops it from the queue; a lookup result
// comes from a walk of one node read per trie level, or straight from the queue when disabled
// throughput: one write per cycle while no lookup is walked or waits on the output; each lookup
// ends before the next item is popped, as its dependent node reads share the single read port of the node store
// reset: queue and output empty, lookup_enable 0; node store contents undefined until
// written, no clearing pass
module ip_country_trie_lookup (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [ictl_pkg::S_TDATA_W-1:0] s_tdata,   // node_index, left_pointer, right_pointer, ip_address
	input  logic                           s_tuser,   // command
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [ictl_pkg::M_TDATA_W-1:0] m_tdata    // country_index, status
);

	logic            lookup_enable_q;
	logic            q_valid;
	logic            q_pop;
	ictl_pkg::item_t q_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lookup_enable_q <= 1'b0;
		end else if (cfg_we) begin
			lookup_enable_q <= cfg_wdata;
		end
	end

	ictl_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	ictl_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.lookup_enable(lookup_enable_q),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata)
	);

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

module tb;

	typedef struct {
		bit                              en;
		logic                            op;
		logic [ictl_pkg::NODE_IDX_W-1:0] idx;
		logic [ictl_pkg::PTR_W-1:0]      lp;
		logic [ictl_pkg::PTR_W-1:0]      rp;
		logic [ictl_pkg::IP_W-1:0]       ip;
		bit                              typed;
		ictl_pkg::result_t               res;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic                           cfg_wdata;
	logic                           s_tvalid;
	logic                           s_tready;
	logic [ictl_pkg::S_TDATA_W-1:0] s_tdata;    // node_index, left_pointer, right_pointer, ip_address
	logic                           s_tuser;    // command
	logic                           m_tvalid;
	logic                           m_tready;
	logic [ictl_pkg::M_TDATA_W-1:0] m_tdata;    // country_index, status

	logic [ictl_pkg::PTR_W-1:0] trie_left [int unsigned];
	logic [ictl_pkg::PTR_W-1:0] trie_right [int unsigned];
	int unsigned                written_nodes [$];
	ictl_pkg::result_t          pending_results [$];
	bit                         lookup_en;

	int tx_idle_pct;
	int rx_stall_pct;
	int fail_count;
	int items_sent;
	int write_count;
	int lookup_count;
	int st_count [5];

	int phase_en [6]    = '{1, 1, 1, 1, 0, 1};
	int phase_idle [6]  = '{0, 61, 0, 31, 31, 0};
	int phase_stall [6] = '{0, 0, 61, 31, 31, 0};
	int phase_len [6]   = '{400, 400, 400, 400, 100, 200};

	row_t dir_rows [21];

	ip_country_trie_lookup u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic ictl_pkg::result_t walk_trie(input logic [ictl_pkg::IP_W-1:0] ip);
		ictl_pkg::result_t          r;
		logic [ictl_pkg::PTR_W-1:0] ptr;
		int unsigned                node;
		int                         lvl;
		r.status        = ictl_pkg::ST_EXHAUSTED;
		r.country_index = '0;
		if (!lookup_en) begin
			r.status = ictl_pkg::ST_DISABLED;
			return r;
		end
		node = 0;
		for (lvl = ictl_pkg::IP_W - 1; lvl >= 0; lvl--) begin
			if (node >= ictl_pkg::NODE_COUNT) begin
				r.status = ictl_pkg::ST_BEYOND;
				return r;
			end
			ptr = ip[lvl] ? trie_right[node] : trie_left[node];
			if (ptr >= ictl_pkg::TERMINAL_BASE) begin
				if (32'(ptr - ictl_pkg::TERMINAL_BASE) >= ictl_pkg::COUNTRY_COUNT) begin
					r.status = ictl_pkg::ST_RANGE;
				end else begin
					r.status        = ictl_pkg::ST_FOUND;
					r.country_index = ictl_pkg::IDX_W'(ptr - ictl_pkg::TERMINAL_BASE);
				end
				return r;
			end
			node = 32'(ptr);
		end
		return r;
	endfunction

	// node pointer, terminal code or pointer past the table
	function automatic logic [ictl_pkg::PTR_W-1:0] pick_pointer();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 50)
			return ictl_pkg::PTR_W'(written_nodes[$urandom_range(written_nodes.size() - 1)]);
		if (r < 80)
			return ictl_pkg::TERMINAL_BASE + ictl_pkg::PTR_W'($urandom_range(255));
		return ictl_pkg::PTR_W'($urandom_range(16776959, ictl_pkg::NODE_COUNT));
	endfunction

	task automatic send_item(input logic op, input logic [ictl_pkg::NODE_IDX_W-1:0] idx,
			input logic [ictl_pkg::PTR_W-1:0] lp, input logic [ictl_pkg::PTR_W-1:0] rp,
			input logic [ictl_pkg::IP_W-1:0] ip, input bit typed,
			input ictl_pkg::result_t typed_res);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {6'd0, ip, rp, lp, idx};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		items_sent++;
		if (op == ictl_pkg::OP_WRITE) begin
			if (!trie_left.exists(idx))
				written_nodes.push_back(idx);
			trie_left[idx]  = lp;
			trie_right[idx] = rp;
			write_count++;
		end else begin
			pending_results.push_back(typed ? typed_res : walk_trie(ip));
			lookup_count++;
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic set_enable(input bit v);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		lookup_en = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	always @(posedge clk) begin
		ictl_pkg::result_t got;
		ictl_pkg::result_t want;
		if (m_tvalid && m_tready) begin
			got = ictl_pkg::result_t'(m_tdata[ictl_pkg::ST_W+ictl_pkg::IDX_W-1:0]);
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result transfer, actual index %0d status %0d",
					$time, got.country_index, got.status);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				st_count[want.status]++;
				if (got.country_index !== want.country_index) begin
					$display("%0t: country_index mismatch, expected %0d actual %0d",
						$time, want.country_index, got.country_index);
					fail_count++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status mismatch, expected %0d actual %0d",
						$time, want.status, got.status);
					fail_count++;
				end
			end
		end
		m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	initial begin
		#4_000_000;
		$display("** ip_country_trie_lookup: FAILED **");
		$finish;
	end

	initial begin
		int                         i;
		int                         ph;
		int                         k;
		int                         depth;
		int                         start;
		int unsigned                roll;
		int unsigned                path [32];
		logic [ictl_pkg::IP_W-1:0]  addr;
		logic [ictl_pkg::PTR_W-1:0] next_ptr;
		logic [ictl_pkg::PTR_W-1:0] other;
		clk          = 1'b0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = 1'b0;
		lookup_en    = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		fail_count   = 0;
		items_sent   = 0;
		write_count  = 0;
		lookup_count = 0;
		st_count     = '{0, 0, 0, 0, 0};

		dir_rows = '{
			'{0, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'h0000_0000, 1,
				'{ictl_pkg::ST_DISABLED, 8'd0}},
			'{0, ictl_pkg::OP_LOOKUP, 18'h3ffff, 24'hffffff, 24'hffffff, 32'hffff_ffff, 1,
				'{ictl_pkg::ST_DISABLED, 8'd0}},
			'{0, ictl_pkg::OP_WRITE, 18'd0, ictl_pkg::TERMINAL_BASE + 24'd254, 24'd1, 32'd0,
				0, '0},
			'{0, ictl_pkg::OP_WRITE, 18'd1, ictl_pkg::TERMINAL_BASE, 24'd2, 32'd0, 0, '0},
			'{0, ictl_pkg::OP_WRITE, 18'd2, 24'hffffff, 24'd3, 32'd0, 0, '0},
			'{0, ictl_pkg::OP_WRITE, 18'd3, 24'd262144, 24'd4, 32'd0, 0, '0},
			'{0, ictl_pkg::OP_WRITE, 18'd4, 24'd16776959, 24'd262143, 32'd0, 0, '0},
			'{0, ictl_pkg::OP_WRITE, 18'h3ffff, 24'd262143, 24'd5, 32'hffff_ffff, 0, '0},
			'{0, ictl_pkg::OP_WRITE, 18'd5, 24'd5, 24'd300000, 32'd0, 0, '0},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'h7fff_ffff, 1,
				'{ictl_pkg::ST_FOUND, 8'd254}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'h8000_0000, 1,
				'{ictl_pkg::ST_FOUND, 8'd0}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'hc000_0000, 1,
				'{ictl_pkg::ST_RANGE, 8'd0}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'he000_0000, 1,
				'{ictl_pkg::ST_BEYOND, 8'd0}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'hf000_0000, 1,
				'{ictl_pkg::ST_BEYOND, 8'd0}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'hf800_0000, 1,
				'{ictl_pkg::ST_EXHAUSTED, 8'd0}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'hfc00_0001, 1,
				'{ictl_pkg::ST_EXHAUSTED, 8'd0}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'hfc00_0003, 1,
				'{ictl_pkg::ST_BEYOND, 8'd0}},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'hffff_ffff, 1,
				'{ictl_pkg::ST_BEYOND, 8'd0}},
			'{1, ictl_pkg::OP_WRITE, 18'd0, ictl_pkg::TERMINAL_BASE + 24'd5, 24'd1, 32'd0,
				0, '0},
			'{1, ictl_pkg::OP_LOOKUP, 18'd0, 24'd0, 24'd0, 32'h1234_5678, 0, '0},
			'{1, ictl_pkg::OP_WRITE, 18'h3fffe, 24'hffffff, 24'd0, 32'd0, 0, '0}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < $size(dir_rows); i++) begin
			if (dir_rows[i].en != lookup_en)
				set_enable(dir_rows[i].en);
			send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].lp, dir_rows[i].rp,
				dir_rows[i].ip, dir_rows[i].typed, dir_rows[i].res);
		end

		for (ph = 0; ph < 6; ph++) begin
			set_enable(phase_en[ph] != 0);
			tx_idle_pct  = phase_idle[ph];
			rx_stall_pct = phase_stall[ph];
			start        = items_sent;
			while (items_sent - start < phase_len[ph]) begin
				roll = $urandom_range(99);
				if (roll < 8) begin
					send_item(ictl_pkg::OP_WRITE,
						ictl_pkg::NODE_IDX_W'($urandom_range(ictl_pkg::NODE_COUNT - 1)),
						pick_pointer(), pick_pointer(), ictl_pkg::IP_W'($urandom()), 0, '0);
				end else if (roll < 15) begin
					send_item(ictl_pkg::OP_LOOKUP, ictl_pkg::NODE_IDX_W'($urandom()),
						ictl_pkg::PTR_W'($urandom()), ictl_pkg::PTR_W'($urandom()),
						ictl_pkg::IP_W'($urandom()), 0, '0);
				end else begin
					// build a path for one address bottom up, then look it up
					addr = ictl_pkg::IP_W'($urandom());
					roll = $urandom_range(99);
					if (roll < 70)
						depth = $urandom_range(8, 1);
					else if (roll < 90)
						depth = $urandom_range(20, 9);
					else
						depth = $urandom_range(32, 21);
					path[0] = 0;
					for (k = 1; k < depth; k++)
						path[k] = ($urandom_range(99) < 70) ? $urandom_range(63, 1)
							: $urandom_range(ictl_pkg::NODE_COUNT - 1, 1);
					if ($urandom_range(99) < 80)
						next_ptr = ictl_pkg::TERMINAL_BASE
							+ ictl_pkg::PTR_W'($urandom_range(255));
					else
						next_ptr = pick_pointer();
					for (k = depth - 1; k >= 0; k--) begin
						other = pick_pointer();
						if (addr[31-k])
							send_item(ictl_pkg::OP_WRITE, ictl_pkg::NODE_IDX_W'(path[k]),
								other, next_ptr, ictl_pkg::IP_W'($urandom()), 0, '0);
						else
							send_item(ictl_pkg::OP_WRITE, ictl_pkg::NODE_IDX_W'(path[k]),
								next_ptr, other, ictl_pkg::IP_W'($urandom()), 0, '0);
						next_ptr = ictl_pkg::PTR_W'(path[k]);
					end
					repeat ($urandom_range(3, 1)) begin
						send_item(ictl_pkg::OP_LOOKUP, ictl_pkg::NODE_IDX_W'($urandom()),
							ictl_pkg::PTR_W'($urandom()), ictl_pkg::PTR_W'($urandom()),
							addr, 0, '0);
						addr = addr ^ (ictl_pkg::IP_W'($urandom()) >> $urandom_range(31));
					end
				end
			end
		end

		drain();
		$display("covered %0d node writes and %0d lookups across idle, stall and disabled mixes",
			write_count, lookup_count);
		$display("lookup outcomes: found %0d, disabled %0d, range %0d, exhausted %0d, beyond %0d",
			st_count[0], st_count[1], st_count[2], st_count[3], st_count[4]);
		if (fail_count == 0) begin
			$display("** ip_country_trie_lookup: PASSED **");
		end else begin
			$display("** ip_country_trie_lookup: FAILED **");
		end
		$finish;
	end

endmodule
